[sv/spi_frame_receiver_crc8_macros.svh]
// assertion macros for the spi frame receiver, used by the frame engine
`ifndef SPI_FRAME_RECEIVER_CRC8_MACROS_SVH
`define SPI_FRAME_RECEIVER_CRC8_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SFRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfrc assertion failed");

// consequent checked in the cycle after the antecedent
`define SFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfrc assertion failed");

`endif

[sv/sfrc_pkg.sv]
// package with constants, types and crc functions of the spi frame receiver
package sfrc_pkg;

    localparam int PAYLOAD_WORDS = 3;
    localparam int PAYLOAD_BYTES = PAYLOAD_WORDS * 4;
    localparam int MSG_BYTES     = PAYLOAD_BYTES + 1;
    localparam int MSG_BITS      = MSG_BYTES * 8;
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 2);

    localparam logic [7:0] CRC_POLY          = 8'h07;
    localparam logic [7:0] MASTER_HEADER_RST = 8'h55;
    localparam logic [7:0] SLAVE_HEADER_RST  = 8'h45;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_HEADER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_HEADER  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_LOW     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPLY_HIGH    = 2'd3;

    typedef struct packed {
        logic [7:0]  master_header;
        logic [7:0]  slave_header;
        logic [63:0] reply_low;
        logic [31:0] reply_high;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        frame_done;
        logic        frame_ok;
        logic [63:0] payload_low;
        logic [31:0] payload_high;
        logic [31:0] good_count;
        logic [31:0] crc_fail_count;
        logic [7:0]  computed_crc;
    } result_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // crc of a zero-init message that has only bit j set
    function automatic logic [7:0] reply_crc_basis(input int unsigned j);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        for (int unsigned m = 0; m < MSG_BYTES; m++)
        begin
            b = (m == (j >> 3)) ? (8'h01 << j[2:0]) : 8'h00;
            crc = crc8_step(crc, b);
        end
        return crc;
    endfunction

endpackage

[sv/sfrc_channels.sv]
// byte request channel and result channel interfaces
interface sfrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_byte;
    logic        frame_done;
    logic        frame_ok;
    logic [63:0] payload_low;
    logic [31:0] payload_high;
    logic [31:0] good_count;
    logic [31:0] crc_fail_count;
    logic [7:0]  computed_crc;

    modport source (output valid, output reply_byte, output frame_done, output frame_ok,
                    output payload_low, output payload_high, output good_count,
                    output crc_fail_count, output computed_crc, input ready);
    modport sink (input valid, input reply_byte, input frame_done, input frame_ok,
                  input payload_low, input payload_high, input good_count,
                  input crc_fail_count, input computed_crc, output ready);
endinterface

[sv/spi_frame_receiver_crc8.sv]
// top level of the crc-8 framed spi byte receiver
//
//  channel  dir  handshake      payload
//  rx       in   valid/ready    rx_byte
//  res      out  valid/ready    reply_byte, frame flags, payload, counters, crc
//  cfg      in   cfg_write      cfg_index, cfg_data
//
// one byte request per cycle sustained while res is ready; a result passes the input register, then the result register
// input register and result register separate the sides; rx.ready drops only when both hold
// reset clears framing state, counters and held payload at once, no clearing pass
// reply crc is a registered xor tree over the reply config, refreshed every cycle
module spi_frame_receiver_crc8 (
    input  logic                            clk,
    input  logic                            rst_n,
    sfrc_rx_if.sink                         rx,
    sfrc_res_if.source                      res,
    input  logic                            cfg_write,
    input  logic [sfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfrc_pkg::*;

    cfg_t cfg;

    sfrc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfrc_frame_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );
endmodule

[sv/sfrc_cfg_regs.sv]
// configuration register file
module sfrc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sfrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfrc_pkg::cfg_t                  cfg
);
    import sfrc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_MASTER_HEADER: cfg_next.master_header = cfg_data[7:0];
                CFG_SLAVE_HEADER:  cfg_next.slave_header  = cfg_data[7:0];
                CFG_REPLY_LOW:     cfg_next.reply_low     = cfg_data[63:0];
                CFG_REPLY_HIGH:    cfg_next.reply_high    = cfg_data[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_header <= MASTER_HEADER_RST;
            cfg_reg.slave_header  <= SLAVE_HEADER_RST;
            cfg_reg.reply_low     <= '0;
            cfg_reg.reply_high    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

[sv/sfrc_reply_gen.sv]
// reply byte selection and registered crc of the reply frame
module sfrc_reply_gen (
    input  logic                      clk,
    input  sfrc_pkg::cfg_t            cfg,
    input  logic [sfrc_pkg::POS_W-1:0] reply_pos,
    output logic [7:0]                reply_byte
);
    import sfrc_pkg::*;

    logic [95:0]          reply_all;
    logic [MSG_BITS-1:0]  msg;
    logic [7:0]           term [MSG_BITS];
    logic [7:0]           reply_crc_next;
    logic [7:0]           reply_crc_reg;

    assign reply_all = {cfg.reply_high, cfg.reply_low};
    assign msg       = {reply_all[PAYLOAD_BYTES*8-1:0], cfg.slave_header};

    // crc is linear in the message bits: xor of per-bit contributions
    for (genvar j = 0; j < MSG_BITS; j++)
    begin : g_basis
        localparam logic [7:0] BASIS = reply_crc_basis(j);
        assign term[j] = msg[j] ? BASIS : 8'h00;
    end

    always_comb
    begin
        reply_crc_next = 8'h00;
        for (int j = 0; j < MSG_BITS; j++)
        begin
            reply_crc_next = reply_crc_next ^ term[j];
        end
    end

    // the user keeps config changes to idle time; the block does not enforce it; lag is covered by the input stage
    always_ff @(posedge clk)
    begin
        reply_crc_reg <= reply_crc_next;
    end

    always_comb
    begin
        reply_byte = reply_crc_reg;
        if (reply_pos == '0)
        begin
            reply_byte = cfg.slave_header;
        end
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            if (reply_pos == POS_W'(i + 1))
            begin
                reply_byte = reply_all[i*8 +: 8];
            end
        end
    end
endmodule

[sv/sfrc_frame_engine.sv]
// input stage, framing and crc check, payload store, counters and result register
`include "spi_frame_receiver_crc8_macros.svh"
module sfrc_frame_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  sfrc_pkg::cfg_t cfg,
    sfrc_rx_if.sink        rx,
    sfrc_res_if.source     res
);
    import sfrc_pkg::*;

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          out_next;
    logic             adv;
    logic             fire;

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [31:0]      good_reg, good_next;
    logic [31:0]      bad_reg, bad_next;
    logic [7:0]       store_reg [PAYLOAD_BYTES];
    logic [31:0]      held_reg [3];
    logic [31:0]      held_next [3];
    logic [31:0]      store_word [3];

    logic             store_en;
    logic             latch_en;
    logic [POS_W-1:0] reply_pos;
    logic [7:0]       reply_byte;

    assign adv      = !out_valid_reg || res.ready;
    assign fire     = s1_valid_reg && adv;
    assign rx.ready = !s1_valid_reg || adv;

    sfrc_reply_gen u_reply (
        .clk        (clk),
        .cfg        (cfg),
        .reply_pos  (reply_pos),
        .reply_byte (reply_byte)
    );

    for (genvar w = 0; w < 3; w++)
    begin : g_word
        if (w < PAYLOAD_WORDS)
        begin : g_used
            assign store_word[w] = {store_reg[w*4+3], store_reg[w*4+2],
                                    store_reg[w*4+1], store_reg[w*4]};
            assign held_next[w]  = latch_en ? store_word[w] : held_reg[w];
        end
        else
        begin : g_unused
            assign store_word[w] = 32'h0;
            assign held_next[w]  = held_reg[w];
        end
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        store_en      = 1'b0;
        latch_en      = 1'b0;
        reply_pos     = '0;
        out_next.frame_done   = 1'b0;
        out_next.frame_ok     = 1'b0;
        out_next.computed_crc = 8'h00;

        if (!in_frame_reg)
        begin
            if (s1_byte_reg == cfg.master_header)
            begin
                in_frame_next = 1'b1;
                pos_next      = POS_W'(1);
                crc_next      = crc8_step(8'h00, s1_byte_reg);
                reply_pos     = POS_W'(1);
            end
        end
        else if (pos_reg >= POS_W'(1) && pos_reg <= POS_W'(PAYLOAD_BYTES))
        begin
            store_en  = fire;
            crc_next  = crc8_step(crc_reg, s1_byte_reg);
            pos_next  = pos_reg + POS_W'(1);
            reply_pos = pos_reg + POS_W'(1);
        end
        else
        begin
            // trailing crc byte closes the frame
            out_next.frame_done   = 1'b1;
            out_next.computed_crc = crc_reg;
            if (crc_reg == s1_byte_reg)
            begin
                out_next.frame_ok = 1'b1;
                latch_en          = 1'b1;
                good_next         = good_reg + 32'd1;
            end
            else
            begin
                bad_next = bad_reg + 32'd1;
            end
            in_frame_next = 1'b0;
            pos_next      = '0;
            crc_next      = 8'h00;
        end

        out_next.reply_byte     = reply_byte;
        out_next.payload_low    = {held_next[1], held_next[0]};
        out_next.payload_high   = held_next[2];
        out_next.good_count     = good_next;
        out_next.crc_fail_count = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            crc_reg       <= 8'h00;
            good_reg      <= 32'h0;
            bad_reg       <= 32'h0;
            for (int w = 0; w < 3; w++)
            begin
                held_reg[w] <= 32'h0;
            end
        end
        else
        begin
            if (rx.ready)
            begin
                s1_valid_reg <= rx.valid;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
                crc_reg      <= crc_next;
                good_reg     <= good_next;
                bad_reg      <= bad_next;
                for (int w = 0; w < 3; w++)
                begin
                    held_reg[w] <= held_next[w];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            if (store_en && pos_reg == POS_W'(i + 1))
            begin
                store_reg[i] <= s1_byte_reg;
            end
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.reply_byte     = out_reg.reply_byte;
    assign res.frame_done     = out_reg.frame_done;
    assign res.frame_ok       = out_reg.frame_ok;
    assign res.payload_low    = out_reg.payload_low;
    assign res.payload_high   = out_reg.payload_high;
    assign res.good_count     = out_reg.good_count;
    assign res.crc_fail_count = out_reg.crc_fail_count;
    assign res.computed_crc   = out_reg.computed_crc;

    `SFRC_ASSERT_NOW(a_hunt_clean, clk, rst_n, !in_frame_reg, pos_reg == '0 && crc_reg == 8'h00)
    `SFRC_ASSERT_NOW(a_pos_range, clk, rst_n, in_frame_reg, pos_reg >= POS_W'(1) && pos_reg <= POS_W'(PAYLOAD_BYTES + 1))
    `SFRC_ASSERT_NEXT(a_good_bump, clk, rst_n, fire && latch_en, good_reg == $past(good_reg) + 32'd1 && !in_frame_reg)
    `SFRC_ASSERT_NOW(a_not_done_zero, clk, rst_n, out_valid_reg && !out_reg.frame_done, !out_reg.frame_ok && out_reg.computed_crc == 8'h00)
endmodule

[tb/spi_frame_receiver_crc8_tb.sv]
// self-checking testbench for the crc-8 framed spi byte receiver
module spi_frame_receiver_crc8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfrc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 80;
    localparam int BODY_W        = 8 * PAYLOAD_BYTES;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sfrc_rx_if  rx_ch ();
    sfrc_res_if res_ch ();

    spi_frame_receiver_crc8 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .res       (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    cfg_t        cur_cfg;
    bit          hunting_done;
    int unsigned frame_pos;
    logic [7:0]  frame_crc;
    logic [7:0]  frame_bytes [PAYLOAD_BYTES];
    logic [31:0] held_words [3];
    logic [31:0] good_total;
    logic [31:0] bad_total;

    result_t     expected_results [$];
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          src_gaps;
    bit          sink_stalls;
    int          hold_request;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        acc = crc ^ data;
        repeat (8)
        begin
            acc = (acc << 1) ^ (acc[7] ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // reply frame: slave header, reply payload, crc over both
    function automatic logic [7:0] reply_byte_at(input int unsigned pos);
        logic [95:0] body;
        logic [7:0]  crc;
        int          i;
        body = {cur_cfg.reply_high, cur_cfg.reply_low};
        if (pos == 0)
            return cur_cfg.slave_header;
        if (pos <= PAYLOAD_BYTES)
            return body[8*(pos-1) +: 8];
        crc = crc8_byte(8'h00, cur_cfg.slave_header);
        for (i = 0; i < PAYLOAD_BYTES; i++)
            crc = crc8_byte(crc, body[8*i +: 8]);
        return crc;
    endfunction

    function automatic result_t next_frame_result(input logic [7:0] b);
        result_t r;
        int      w;
        r = '0;
        if (!hunting_done)
        begin
            if (b == cur_cfg.master_header)
            begin
                hunting_done = 1'b1;
                frame_pos    = 1;
                frame_crc    = crc8_byte(8'h00, b);
            end
            r.reply_byte = reply_byte_at(frame_pos);
        end
        else if (frame_pos <= PAYLOAD_BYTES)
        begin
            frame_bytes[frame_pos-1] = b;
            frame_crc = crc8_byte(frame_crc, b);
            frame_pos++;
            r.reply_byte = reply_byte_at(frame_pos);
        end
        else
        begin
            r.frame_done   = 1'b1;
            r.computed_crc = frame_crc;
            if (frame_crc == b)
            begin
                r.frame_ok = 1'b1;
                for (w = 0; w < PAYLOAD_WORDS; w++)
                    held_words[w] = {frame_bytes[4*w+3], frame_bytes[4*w+2],
                                     frame_bytes[4*w+1], frame_bytes[4*w]};
                good_total++;
            end
            else
            begin
                bad_total++;
            end
            hunting_done = 1'b0;
            frame_pos    = 0;
            frame_crc    = 8'h00;
            r.reply_byte = reply_byte_at(0);
        end
        r.payload_low    = {held_words[1], held_words[0]};
        r.payload_high   = held_words[2];
        r.good_count     = good_total;
        r.crc_fail_count = bad_total;
        return r;
    endfunction

    function automatic logic [7:0] master_frame_crc(input logic [BODY_W-1:0] body);
        logic [7:0] crc;
        int         i;
        crc = crc8_byte(8'h00, cur_cfg.master_header);
        for (i = 0; i < PAYLOAD_BYTES; i++)
            crc = crc8_byte(crc, body[8*i +: 8]);
        return crc;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        @(negedge clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        expected_results.push_back(next_frame_result(b));
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_frame(input logic [BODY_W-1:0] body, input logic [7:0] crc_flip);
        int i;
        send_byte(cur_cfg.master_header);
        for (i = 0; i < PAYLOAD_BYTES; i++)
            send_byte(body[8*i +: 8]);
        send_byte(master_frame_crc(body) ^ crc_flip);
    endtask

    // stop requests and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_MASTER_HEADER: cur_cfg.master_header = value[7:0];
            CFG_SLAVE_HEADER:  cur_cfg.slave_header  = value[7:0];
            CFG_REPLY_LOW:     cur_cfg.reply_low     = value;
            CFG_REPLY_HIGH:    cur_cfg.reply_high    = value[31:0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] master, input logic [7:0] slave,
                                input logic [63:0] reply_low, input logic [31:0] reply_high);
        drain();
        write_reg(CFG_MASTER_HEADER, {56'h0, master});
        write_reg(CFG_SLAVE_HEADER, {56'h0, slave});
        write_reg(CFG_REPLY_LOW, reply_low);
        write_reg(CFG_REPLY_HIGH, {32'h0, reply_high});
        // reply crc is registered, give it time to follow the new settings
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_hunting_and_good_frame();
        logic [BODY_W-1:0] body;
        // non-header bytes while hunting are ignored
        send_byte(8'hFF);
        send_byte(8'h00);
        // extremes plus header values inside the payload
        body = {8'h55, 8'hFF, 8'h00, 8'h55, 8'h80, 8'h01,
                8'hFE, 8'h7F, 8'h55, 8'hAA, 8'hFF, 8'h00};
        send_frame(body, 8'h00);
    endtask

    task automatic test_bad_crc();
        logic [BODY_W-1:0] body;
        logic [7:0]        flip;
        body = '0;
        // crc byte carries the header value
        flip = master_frame_crc(body) ^ cur_cfg.master_header;
        if (flip == 8'h00)
            flip = 8'h01;
        send_frame(body, flip);
    endtask

    task automatic test_backpressure();
        logic [BODY_W-1:0] body;
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (3)
        begin
            body = {$urandom(), $urandom(), $urandom()};
            send_frame(body, 8'h00);
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic run_traffic(input int unsigned target);
        int unsigned       sent;
        int unsigned       roll;
        int unsigned       k;
        int                i;
        logic [BODY_W-1:0] body;
        logic [7:0]        flip;
        sent = 0;
        while (sent < target)
        begin
            roll = $urandom_range(0, 99);
            body = {$urandom(), $urandom(), $urandom()};
            for (i = 0; i < PAYLOAD_BYTES; i++)
            begin
                case ($urandom_range(0, 11))
                    0: body[8*i +: 8] = cur_cfg.master_header;
                    1: body[8*i +: 8] = 8'h00;
                    2: body[8*i +: 8] = 8'hFF;
                    default: ;
                endcase
            end
            if (roll < 72)
            begin
                flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(body, flip);
                sent += PAYLOAD_BYTES + 2;
            end
            else if (roll < 86)
            begin
                // truncated frame, whatever follows is taken as its tail
                k = $urandom_range(1, PAYLOAD_BYTES);
                send_byte(cur_cfg.master_header);
                for (i = 0; i < k; i++)
                    send_byte(body[8*i +: 8]);
                sent += k + 1;
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
            end
        end
    endtask

    task automatic test_config_phases();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_config(8'h00, 8'hFF, {64{1'b1}}, {32{1'b1}});
                1: apply_config(8'hFF, 8'h00, 64'h0, 32'h0);
                default: apply_config(8'($urandom()), 8'($urandom()),
                                      {$urandom(), $urandom()}, $urandom());
            endcase
            // one stretch with no idling on either side
            src_gaps    = (phase != 2);
            sink_stalls = (phase != 2);
            run_traffic(60);
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // receiver side: random stalls and the long hold-off
    initial
    begin
        int unsigned stall_left;
        int          hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stalls)
            begin
                stall_left = pick_gap();
                res_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("reply_byte", 64'(want.reply_byte), 64'(res_ch.reply_byte));
                check_field("frame_done", 64'(want.frame_done), 64'(res_ch.frame_done));
                check_field("frame_ok", 64'(want.frame_ok), 64'(res_ch.frame_ok));
                check_field("payload_low", want.payload_low, res_ch.payload_low);
                check_field("payload_high", 64'(want.payload_high),
                            64'(res_ch.payload_high));
                check_field("good_count", 64'(want.good_count), 64'(res_ch.good_count));
                check_field("crc_fail_count", 64'(want.crc_fail_count),
                            64'(res_ch.crc_fail_count));
                check_field("computed_crc", 64'(want.computed_crc),
                            64'(res_ch.computed_crc));
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int w;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_write     = 1'b0;
        cfg_index     = CFG_MASTER_HEADER;
        cfg_data      = '0;
        cur_cfg       = {MASTER_HEADER_RST, SLAVE_HEADER_RST, 64'h0, 32'h0};
        hunting_done  = 1'b0;
        frame_pos     = 0;
        frame_crc     = 8'h00;
        for (w = 0; w < 3; w++)
            held_words[w] = 32'h0;
        good_total    = 32'h0;
        bad_total     = 32'h0;
        mismatches    = 0;
        idle_cycles   = 0;
        src_gaps      = 1'b1;
        sink_stalls   = 1'b1;
        hold_request  = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_hunting_and_good_frame();
        test_bad_crc();
        test_backpressure();
        test_config_phases();

        drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sfrc_pkg.sv
sv/sfrc_channels.sv
sv/sfrc_cfg_regs.sv
sv/sfrc_reply_gen.sv
sv/sfrc_frame_engine.sv
sv/spi_frame_receiver_crc8.sv
tb/spi_frame_receiver_crc8_tb.sv
